/* src/sbc_pkg.sv */
// Shared constants and types for the simplex barycentric containment block.
// No dependencies; the other files that use it refer to this package by scoped names.
package sbc_pkg;

  // Configuration register file layout.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REG_W     = 48;
  localparam int unsigned SLOT_W    = 16;
  localparam int unsigned NUM_REGS  = 4;

  // Fixed field widths of the request and result channels.
  localparam int unsigned POINT_W  = 16;
  localparam int unsigned WEIGHT_W = 32;

  // Number of quotient bits the divider develops, one per pipeline step.
  localparam int unsigned QUOT_W = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_A    = 2'd0,
    CFG_VERTEX_B    = 2'd1,
    CFG_VERTEX_C    = 2'd2,
    CFG_VERTEX_LAST = 2'd3
  } cfg_reg_e;

endpackage

/* src/sbc_if.sv */
// Valid/ready channel interfaces for query points and containment results.
// Depends on sbc_pkg for the field widths.
interface sbc_point_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [sbc_pkg::POINT_W-1:0]         point_x;
  logic signed [sbc_pkg::POINT_W-1:0]         point_y;
  logic signed [sbc_pkg::POINT_W-1:0]         point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface sbc_result_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [sbc_pkg::WEIGHT_W-1:0]        weight_a;
  logic signed [sbc_pkg::WEIGHT_W-1:0]        weight_b;
  logic signed [sbc_pkg::WEIGHT_W-1:0]        weight_c;
  logic signed [sbc_pkg::WEIGHT_W-1:0]        weight_last;
  logic                                       inside_res;
  logic                                       degenerate;

  modport source (output valid, weight_a, weight_b, weight_c, weight_last,
                  inside_res, degenerate, input ready);
  modport sink   (input valid, weight_a, weight_b, weight_c, weight_last,
                  inside_res, degenerate, output ready);
endinterface

/* src/sbc_det3.sv */
// Four-stage pipelined 3x3 determinant: products, minors, terms, sum.
// Standalone; stalls with the shared pipeline enable.
module sbc_det3 #(
  parameter int unsigned EW = 17
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [EW-1:0]   c0_i [3],
  input  logic signed [EW-1:0]   c1_i [3],
  input  logic signed [EW-1:0]   c2_i [3],
  output logic signed [3*EW+2:0] det_o
);

  localparam int unsigned PW = 2 * EW;
  localparam int unsigned MW = 2 * EW + 1;
  localparam int unsigned TW = 3 * EW + 1;
  localparam int unsigned DW = 3 * EW + 3;

  logic signed [PW-1:0] prod_q [6];
  logic signed [EW-1:0] row1_q [3];
  logic signed [MW-1:0] minor_q [3];
  logic signed [EW-1:0] row2_q [3];
  logic signed [TW-1:0] term_q [3];
  logic signed [DW-1:0] det_q;

  // Stage 1: the six products of the lower two rows.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= c1_i[1] * c2_i[2];
      prod_q[1] <= c2_i[1] * c1_i[2];
      prod_q[2] <= c0_i[1] * c2_i[2];
      prod_q[3] <= c2_i[1] * c0_i[2];
      prod_q[4] <= c0_i[1] * c1_i[2];
      prod_q[5] <= c1_i[1] * c0_i[2];
      row1_q[0] <= c0_i[0];
      row1_q[1] <= c1_i[0];
      row1_q[2] <= c2_i[0];
    end
  end

  // Stage 2: the 2x2 minors of the top row entries.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      minor_q[0] <= MW'(prod_q[0]) - MW'(prod_q[1]);
      minor_q[1] <= MW'(prod_q[2]) - MW'(prod_q[3]);
      minor_q[2] <= MW'(prod_q[4]) - MW'(prod_q[5]);
      row2_q     <= row1_q;
    end
  end

  // Stage 3: cofactor terms.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q[0] <= TW'(row2_q[0] * minor_q[0]);
      term_q[1] <= TW'(row2_q[1] * minor_q[1]);
      term_q[2] <= TW'(row2_q[2] * minor_q[2]);
    end
  end

  // Stage 4: alternating sum of the terms.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q <= DW'(term_q[0]) - DW'(term_q[1]) + DW'(term_q[2]);
    end
  end

  assign det_o = det_q;

endmodule

/* src/sbc_div.sv */
// Pipelined fixed-point divider: an entry stage with the overflow check,
// one restoring step per quotient bit, then saturation and sign. Uses sbc_pkg.
module sbc_div #(
  parameter int unsigned NW            = 59,
  parameter int unsigned DW            = 57,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [NW-1:0]                       num_i,
  input  logic                                neg_i,
  input  logic [DW-1:0]                       den_i,
  output logic signed [sbc_pkg::WEIGHT_W-1:0] weight_o
);

  localparam int unsigned QW = sbc_pkg::QUOT_W;
  localparam int unsigned SH = QW - FRACTION_BITS;
  localparam int unsigned XW = NW + QW;

  logic [XW-1:0] num_x;
  logic [XW-1:0] den_x;

  logic [DW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];

  assign num_x = XW'(num_i);
  assign den_x = XW'(den_i) << SH;

  // Entry stage: whole-part overflow check and the starting remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (num_x >= den_x);
      rem_q[0] <= DW'(num_i >> SH);
      low_q[0] <= QW'(num_x << FRACTION_BITS);
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
    end
  end

  // One restoring subtract per stage, most significant quotient bit first.
  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [DW-1:0] trial;
    logic          fits;
    assign trial = {rem_q[s-1][DW-2:0], low_q[s-1][QW-1]};
    assign fits  = (trial >= den_q[s-1]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= fits ? trial - den_q[s-1] : trial;
        quo_q[s] <= {quo_q[s-1][QW-2:0], fits};
        low_q[s] <= {low_q[s-1][QW-2:0], 1'b0};
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  // Saturate to the largest magnitude of the sign, then apply the sign.
  logic [QW-1:0] lim;
  logic [QW-1:0] mag;
  assign lim      = neg_q[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  assign mag      = (ovf_q[QW] || quo_q[QW] > lim) ? lim : quo_q[QW];
  assign weight_o = neg_q[QW] ? -signed'(mag) : signed'(mag);

endmodule

/* src/simplex_barycentric_containment.sv */
// Channel   Dir  Fields                                          Handshake
// req_i     in   point_x, point_y, point_z                       valid/ready
// res_o     out  weight_a/b/c/last, inside_res, degenerate       valid/ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                 write only
//
// One request enters per cycle while the pipeline is not frozen; a result is presented
// after its request passes the input stage, 4 determinant stages, 2 normalize stages,
// 33 divider stages and then the output register. The divider, one quotient bit
// per stage, sets the depth. Reset clears all valid bits and the vertices.
// A stalled result freezes the pipeline only when its last stage is full.
// Depends on sbc_pkg, sbc_if, sbc_det3 and sbc_div.
module simplex_barycentric_containment #(
  parameter int unsigned DIMENSION     = 3,
  parameter int unsigned COORD_WIDTH   = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sbc_pkg::REG_W-1:0]       cfg_data_i,
  sbc_point_if.sink                       req_i,
  sbc_result_if.source                    res_o
);

  localparam int unsigned EW   = COORD_WIDTH + 1;
  localparam int unsigned DW   = 3 * EW + 3;
  localparam int unsigned NW   = DW + 2;
  localparam int unsigned LAST = 7 + sbc_pkg::QUOT_W;
  localparam int unsigned WW   = sbc_pkg::WEIGHT_W;

  // Coordinate of a slot or point field: low COORD_WIDTH bits, sign-extended.
  function automatic logic signed [EW-1:0] coord(input logic [sbc_pkg::SLOT_W-1:0] slot);
    return EW'(signed'(slot[COORD_WIDTH-1:0]));
  endfunction

  logic [sbc_pkg::REG_W-1:0] vtx_q [sbc_pkg::NUM_REGS];
  logic [LAST:0]             v_q;
  logic                      en;
  logic                      res_load;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbc_pkg::NUM_REGS; i++) vtx_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (sbc_pkg::cfg_reg_e'(cfg_idx_i))
        sbc_pkg::CFG_VERTEX_A:    vtx_q[sbc_pkg::CFG_VERTEX_A]    <= cfg_data_i;
        sbc_pkg::CFG_VERTEX_B:    vtx_q[sbc_pkg::CFG_VERTEX_B]    <= cfg_data_i;
        sbc_pkg::CFG_VERTEX_C:    vtx_q[sbc_pkg::CFG_VERTEX_C]    <= cfg_data_i;
        sbc_pkg::CFG_VERTEX_LAST: vtx_q[sbc_pkg::CFG_VERTEX_LAST] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves unless its last stage is full and the result is held.
  assign res_load    = res_o.ready || !res_o.valid;
  assign en          = res_load || !v_q[LAST];
  assign req_i.ready = en;

  // Edge vectors relative to the reference vertex; in the plane the third
  // column is the z unit vector, which reduces the 3x3 to the 2x2 case.
  logic signed [EW-1:0] base [3];
  logic signed [EW-1:0] ea_q [3];
  logic signed [EW-1:0] eb_q [3];
  logic signed [EW-1:0] ec_q [3];
  logic signed [EW-1:0] rp_q [3];
  logic signed [EW-1:0] pt   [3];

  for (genvar k = 0; k < 3; k++) begin : g_base
    assign base[k] = coord(vtx_q[sbc_pkg::CFG_VERTEX_LAST][16*k +: 16]);
  end
  assign pt[0] = coord(req_i.point_x);
  assign pt[1] = coord(req_i.point_y);
  assign pt[2] = coord(req_i.point_z);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ea_q[k] <= coord(vtx_q[sbc_pkg::CFG_VERTEX_A][16*k +: 16]) - base[k];
      eb_q[k] <= coord(vtx_q[sbc_pkg::CFG_VERTEX_B][16*k +: 16]) - base[k];
      if (DIMENSION == 2) begin
        ec_q[k] <= (k == 2) ? EW'(1) : '0;
      end else begin
        ec_q[k] <= coord(vtx_q[sbc_pkg::CFG_VERTEX_C][16*k +: 16]) - base[k];
      end
    end
  end

  // Input stage: query point relative to the reference vertex.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) rp_q[k] <= pt[k] - base[k];
    end
  end

  // Determinant and the three Cramer numerators in parallel.
  logic signed [DW-1:0] det;
  logic signed [DW-1:0] num [3];

  sbc_det3 #(.EW(EW)) u_det (
    .clk_i(clk_i), .en_i(en), .c0_i(ea_q), .c1_i(eb_q), .c2_i(ec_q), .det_o(det));
  sbc_det3 #(.EW(EW)) u_num0 (
    .clk_i(clk_i), .en_i(en), .c0_i(rp_q), .c1_i(eb_q), .c2_i(ec_q), .det_o(num[0]));
  sbc_det3 #(.EW(EW)) u_num1 (
    .clk_i(clk_i), .en_i(en), .c0_i(ea_q), .c1_i(rp_q), .c2_i(ec_q), .det_o(num[1]));
  sbc_det3 #(.EW(EW)) u_num2 (
    .clk_i(clk_i), .en_i(en), .c0_i(ea_q), .c1_i(eb_q), .c2_i(rp_q), .det_o(num[2]));

  // Normalize stage: make the determinant positive, form the last numerator.
  logic signed [NW-1:0] sn [4];
  logic signed [NW-1:0] dpos;
  logic signed [NW-1:0] n_q [4];
  logic signed [NW-1:0] dpos_q;
  logic [LAST:5]        inside_q;
  logic [LAST:5]        degen_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sn[k] = det[DW-1] ? -NW'(num[k]) : NW'(num[k]);
    end
    if (DIMENSION == 2) sn[2] = '0;
    dpos  = det[DW-1] ? -NW'(det) : NW'(det);
    sn[3] = dpos - sn[0] - sn[1] - sn[2];
  end

  // The flags are decided here so that they travel with the numerators.
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q         <= sn;
      dpos_q      <= dpos;
      degen_q[5]  <= (dpos == '0);
      inside_q[5] <= (dpos != '0) && !sn[0][NW-1] && !sn[1][NW-1]
                     && !sn[2][NW-1] && !sn[3][NW-1];
    end
  end

  // Magnitude stage: split each numerator into sign and magnitude.
  logic [NW-1:0] mag_q [4];
  logic          neg_q [4];
  logic [DW-1:0] den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        neg_q[k] <= n_q[k][NW-1];
        mag_q[k] <= n_q[k][NW-1] ? NW'(-n_q[k]) : NW'(n_q[k]);
      end
      den_q <= DW'(dpos_q);
    end
  end

  // Four dividers share the denominator.
  logic signed [WW-1:0] w [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    sbc_div #(.NW(NW), .DW(DW), .FRACTION_BITS(FRACTION_BITS)) u_div (
      .clk_i(clk_i), .en_i(en), .num_i(mag_q[k]), .neg_i(neg_q[k]),
      .den_i(den_q), .weight_o(w[k]));
  end

  // Valid bits and flags follow the data down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 6; s <= LAST; s++) begin
        degen_q[s]  <= degen_q[s-1];
        inside_q[s] <= inside_q[s-1];
      end
    end
  end

  // Output register.
  logic                 res_valid_q;
  logic signed [WW-1:0] res_w_q [4];
  logic                 res_inside_q;
  logic                 res_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= v_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && v_q[LAST]) begin
      for (int k = 0; k < 4; k++) res_w_q[k] <= degen_q[LAST] ? '0 : w[k];
      res_inside_q <= inside_q[LAST];
      res_degen_q  <= degen_q[LAST];
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.weight_a    = res_w_q[0];
  assign res_o.weight_b    = res_w_q[1];
  assign res_o.weight_c    = res_w_q[2];
  assign res_o.weight_last = res_w_q[3];
  assign res_o.inside_res  = res_inside_q;
  assign res_o.degenerate  = res_degen_q;

  // A degenerate simplex never reports a point inside, and weights are zero.
  a_degen_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.degenerate |-> !res_o.inside_res && res_o.weight_a == '0
      && res_o.weight_last == '0)
    else $error("degenerate result carries nonzero weight or inside flag");

  // An inside point has no negative weight.
  a_inside_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.inside_res |-> !res_o.weight_a[WW-1] && !res_o.weight_b[WW-1]
      && !res_o.weight_c[WW-1] && !res_o.weight_last[WW-1])
    else $error("inside result with a negative weight");

  // A frozen pipeline keeps its valid bits.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits changed during a stall");

  // With its last stage empty the pipeline always takes a request.
  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[LAST] |-> req_i.ready)
    else $error("request refused while the pipeline had room");

endmodule

/* tb/sv/tb_simplex_barycentric_containment.sv */
`timescale 1ns / 1ps
// Self-checking testbench for simplex_barycentric_containment: a directed table and then
// random tetrahedra and points, checked against typed rows or an in-bench Cramer's-rule solver.
// Depends on sbc_pkg, sbc_if and the block's RTL.
module tb_simplex_barycentric_containment;

  localparam int FRAC       = 16;
  localparam int LATENCY    = 41;
  localparam int QUIET_MAX  = 3000;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 1000;
  localparam int PHASES     = 8;

  typedef longint vec3_t[3];

  typedef struct {
    logic signed [sbc_pkg::WEIGHT_W-1:0] wa;
    logic signed [sbc_pkg::WEIGHT_W-1:0] wb;
    logic signed [sbc_pkg::WEIGHT_W-1:0] wc;
    logic signed [sbc_pkg::WEIGHT_W-1:0] wl;
    logic                                ins;
    logic                                deg;
  } bary_t;

  typedef struct {
    int                                 tet;
    logic signed [sbc_pkg::POINT_W-1:0] x;
    logic signed [sbc_pkg::POINT_W-1:0] y;
    logic signed [sbc_pkg::POINT_W-1:0] z;
    bit                                 typed;
    bary_t                              want;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [sbc_pkg::REG_W-1:0]     cfg_data_i;

  sbc_point_if  req ();
  sbc_result_if res ();

  simplex_barycentric_containment i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req),
    .res_o      (res)
  );

  // Local copy of the vertex registers.
  logic [sbc_pkg::REG_W-1:0] vtx_a, vtx_b, vtx_c, vtx_last;

  bary_t weights_due[$];
  int    errors = 0;
  int    n_points = 0;
  int    n_checked = 0;
  int    n_inside = 0;
  int    n_degen = 0;
  int    n_sat = 0;
  int    quiet = 0;
  bit    idle_on = 1'b1;
  bit    hold_req = 1'b0;
  int    hold_cnt = 0;

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [sbc_pkg::REG_W-1:0] pack3(int x, int y, int z);
    logic [15:0] px, py, pz;
    px = 16'(x);
    py = 16'(y);
    pz = 16'(z);
    return {pz, py, px};
  endfunction

  function automatic longint coord(logic [sbc_pkg::REG_W-1:0] r, int k);
    logic signed [15:0] s;
    s = r[16*k +: 16];
    return s;
  endfunction

  function automatic longint det3(vec3_t c0, vec3_t c1, vec3_t c2);
    return c0[0] * (c1[1] * c2[2] - c2[1] * c1[2])
         - c1[0] * (c0[1] * c2[2] - c2[1] * c0[2])
         + c2[0] * (c0[1] * c1[2] - c1[1] * c0[2]);
  endfunction

  // Quotient num/den in Q16.16, truncated toward zero and saturated; den is positive.
  function automatic logic signed [31:0] q16_quot(longint num, longint den);
    bit neg;
    longint unsigned n, d, q, r, lim;
    neg = num < 0;
    n = neg ? -num : num;
    d = den;
    q = n / d;
    r = n % d;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > (64'h8000_0000 >> FRAC)) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    for (int i = 0; i < FRAC; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
    end
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // Barycentric weights of a point against the current tetrahedron.
  function automatic bary_t solve_bary(logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z);
    vec3_t ea, eb, ec, rp;
    longint pt[3];
    longint det, base;
    longint num[4];
    bary_t o;
    pt[0] = x;
    pt[1] = y;
    pt[2] = z;
    for (int k = 0; k < 3; k++) begin
      base  = coord(vtx_last, k);
      ea[k] = coord(vtx_a, k) - base;
      eb[k] = coord(vtx_b, k) - base;
      ec[k] = coord(vtx_c, k) - base;
      rp[k] = pt[k] - base;
    end
    det    = det3(ea, eb, ec);
    num[0] = det3(rp, eb, ec);
    num[1] = det3(ea, rp, ec);
    num[2] = det3(ea, eb, rp);
    o = '{default: '0};
    if (det == 0) begin
      o.deg = 1'b1;
      return o;
    end
    if (det < 0) begin
      det = -det;
      for (int k = 0; k < 3; k++) num[k] = -num[k];
    end
    num[3] = det - num[0] - num[1] - num[2];
    o.ins = (num[0] >= 0) && (num[1] >= 0) && (num[2] >= 0) && (num[3] >= 0);
    o.wa = q16_quot(num[0], det);
    o.wb = q16_quot(num[1], det);
    o.wc = q16_quot(num[2], det);
    o.wl = q16_quot(num[3], det);
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  // Writes all four vertices on consecutive edges; the block must be idle.
  task automatic load_tetra(logic [sbc_pkg::REG_W-1:0] a, logic [sbc_pkg::REG_W-1:0] b,
                            logic [sbc_pkg::REG_W-1:0] c, logic [sbc_pkg::REG_W-1:0] l);
    logic [sbc_pkg::REG_W-1:0] vals[4];
    sbc_pkg::cfg_reg_e idx[4];
    vals = '{a, b, c, l};
    idx  = '{sbc_pkg::CFG_VERTEX_A, sbc_pkg::CFG_VERTEX_B, sbc_pkg::CFG_VERTEX_C,
             sbc_pkg::CFG_VERTEX_LAST};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    vtx_a    = a;
    vtx_b    = b;
    vtx_c    = c;
    vtx_last = l;
  endtask

  // Stops offering requests and waits until every result has come back.
  task automatic drain();
    req.valid <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 6) @(posedge clk_i);
  endtask

  // Offers one request, records its expected result once it is taken, and may then idle.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, bit typed, bary_t want);
    req.valid   <= 1'b1;
    req.point_x <= x;
    req.point_y <= y;
    req.point_z <= z;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    weights_due.push_back(typed ? want : solve_bary(x, y, z));
    n_points++;
    if (idle_on && $urandom_range(99) < 38) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Result ready: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      res.ready <= 1'b0;
      hold_cnt--;
    end else begin
      res.ready <= !idle_on || ($urandom_range(99) >= 38);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    bary_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (weights_due.size() == 0) begin
        $display("[%0t] result with no request outstanding", $time);
        errors++;
      end else begin
        want = weights_due.pop_front();
        if (res.weight_a !== want.wa) report_mismatch("weight_a", res.weight_a, want.wa);
        if (res.weight_b !== want.wb) report_mismatch("weight_b", res.weight_b, want.wb);
        if (res.weight_c !== want.wc) report_mismatch("weight_c", res.weight_c, want.wc);
        if (res.weight_last !== want.wl)
          report_mismatch("weight_last", res.weight_last, want.wl);
        if (res.inside_res !== want.ins)
          report_mismatch("inside_res", res.inside_res, want.ins);
        if (res.degenerate !== want.deg)
          report_mismatch("degenerate", res.degenerate, want.deg);
        n_checked++;
        n_inside += want.ins;
        n_degen  += want.deg;
        if (want.wa == 32'h7FFF_FFFF || want.wl == 32'h7FFF_FFFF ||
            want.wl == 32'h8000_0000) n_sat++;
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("[%0t] timeout with %0d results outstanding", $time, weights_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int rnd_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Tetrahedra used by the directed table.
  task automatic load_directed(int tet);
    case (tet)
      0: load_tetra('0, '0, '0, '0);
      1: load_tetra(pack3(1, 0, 0), pack3(0, 1, 0), pack3(0, 0, 1), '0);
      2: load_tetra(pack3(-32767, -32768, -32768), pack3(-32768, -32767, -32768),
                    pack3(-32768, -32768, -32767), pack3(-32768, -32768, -32768));
      3: load_tetra(pack3(32767, -32768, -32768), pack3(-32768, 32767, -32768),
                    pack3(-32768, -32768, 32767), pack3(-32768, -32768, -32768));
      4: load_tetra(pack3(1, 0, 0), pack3(2, 0, 0), pack3(0, 1, 0), '0);
      default: load_tetra(pack3(0, 1, 0), pack3(1, 0, 0), pack3(0, 0, 1), '0);
    endcase
  endtask

  localparam bary_t DEGEN  = '{0, 0, 0, 0, 1'b0, 1'b1};
  localparam bary_t ANY    = '{0, 0, 0, 0, 1'b0, 1'b0};

  // Directed rows; typed expectations only where they follow at a glance.
  row_t rows[] = '{
    '{0, 0, 0, 0, 1, DEGEN},
    '{0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, DEGEN},
    '{0, -16'sh8000, -16'sh8000, -16'sh8000, 1, DEGEN},
    '{1, 0, 0, 0, 1, '{0, 0, 0, 32'h0001_0000, 1'b1, 1'b0}},
    '{1, 1, 0, 0, 1, '{32'h0001_0000, 0, 0, 0, 1'b1, 1'b0}},
    '{1, 0, 1, 0, 1, '{0, 32'h0001_0000, 0, 0, 1'b1, 1'b0}},
    '{1, 0, 0, 1, 1, '{0, 0, 32'h0001_0000, 0, 1'b1, 1'b0}},
    '{1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1,
      '{32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, 32'h8000_0000, 1'b0, 1'b0}},
    '{1, -16'sh8000, 0, 0, 1, '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{1, 1, 1, 1, 0, ANY},
    '{2, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0}},
    '{2, -16'sh8000, -16'sh8000, -16'sh8000, 0, ANY},
    '{3, 0, 0, 0, 0, ANY},
    '{3, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, ANY},
    '{3, -16'sh8000, -16'sh8000, -16'sh8000, 0, ANY},
    '{3, 16'sh5555, -16'sh2AAB, 16'sh1234, 0, ANY},
    '{4, 0, 0, 0, 1, DEGEN},
    '{4, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 1, DEGEN},
    '{5, 1, 0, 0, 1, '{0, 32'h0001_0000, 0, 0, 1'b1, 1'b0}},
    '{5, 0, 0, 0, 0, ANY},
    '{5, -16'sh0003, 16'sh0007, 16'sh0002, 0, ANY}
  };

  // Main sequence.
  initial begin
    int cur_tet;
    int span, pspan, items;
    int ax, ay, az, bx, by, bz, cx, cy, cz, lx, ly, lz;
    logic signed [15:0] px, py, pz;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = sbc_pkg::CFG_VERTEX_A;
    cfg_data_i  = '0;
    req.valid   = 1'b0;
    req.point_x = '0;
    req.point_y = '0;
    req.point_z = '0;
    res.ready   = 1'b0;
    vtx_a = '0;
    vtx_b = '0;
    vtx_c = '0;
    vtx_last = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; the first rows run on the reset state.
    cur_tet = 0;
    foreach (rows[i]) begin
      if (rows[i].tet != cur_tet) begin
        drain();
        cur_tet = rows[i].tet;
        load_directed(cur_tet);
      end
      send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
    end
    drain();

    // Random phases, each with its own tetrahedron.
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(3))
        0: span = 8;
        1: span = 300;
        2: span = 6000;
        default: span = 32767;
      endcase
      lx = rnd_coord(span);  ly = rnd_coord(span);  lz = rnd_coord(span);
      ax = rnd_coord(span);  ay = rnd_coord(span);  az = rnd_coord(span);
      bx = rnd_coord(span);  by = rnd_coord(span);  bz = rnd_coord(span);
      cx = rnd_coord(span);  cy = rnd_coord(span);  cz = rnd_coord(span);
      // One phase with a repeated vertex, a flat tetrahedron.
      if (ph == 6) begin
        cx = ax;  cy = ay;  cz = az;
      end
      load_tetra(pack3(ax, ay, az), pack3(bx, by, bz), pack3(cx, cy, cz), pack3(lx, ly, lz));
      idle_on = (ph != 2);
      if (ph == 4) hold_req = 1'b1;
      pspan = (span > 16383) ? 16383 : span;
      items = RAND_ITEMS / PHASES;
      for (int n = 0; n < items; n++) begin
        if ($urandom_range(99) < 60) begin
          // Near the tetrahedron, where the inside decision flips.
          px = 16'(((ax + bx + cx + lx) >>> 2) + rnd_coord(pspan));
          py = 16'(((ay + by + cy + ly) >>> 2) + rnd_coord(pspan));
          pz = 16'(((az + bz + cz + lz) >>> 2) + rnd_coord(pspan));
        end else begin
          px = 16'($urandom);
          py = 16'($urandom);
          pz = 16'($urandom);
        end
        send_point(px, py, pz, 1'b0, ANY);
      end
      drain();
    end
    idle_on = 1'b1;

    $display("Sent %0d points over %0d tetrahedra; %0d results checked.",
             n_points, PHASES + 6, n_checked);
    $display("%0d inside, %0d degenerate, %0d saturated weights.", n_inside, n_degen, n_sat);
    if (errors == 0 && weights_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sbc_pkg.sv
src/sbc_if.sv
src/sbc_det3.sv
src/sbc_div.sv
src/simplex_barycentric_containment.sv
tb/sv/tb_simplex_barycentric_containment.sv
